### design/srde_pkg.sv
// Shared constants for the signed radix digit emitter.
`timescale 1ns / 1ps
`default_nettype none
package srde_pkg;
   localparam int MAX_RADIX     = 16;
   localparam int TABLE_ENTRIES = 16;
   localparam int DIGIT_W       = 4;    // digit value, 0..TABLE_ENTRIES-1
   localparam int RADIX_W       = 5;
   localparam int CHAR_W        = 8;
   localparam int VALUE_W       = 32;
   localparam int MAX_DIGITS    = 32;
   localparam int COUNT_W       = 6;    // holds 0..MAX_DIGITS
   localparam int INDEX_W       = 5;    // indexes 0..MAX_DIGITS-1
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 64;

   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

   localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_RADIX      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CHARS_LOW  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CHARS_HIGH = 2'd2;
endpackage
`default_nettype wire

### design/signed_radix_digit_emitter_unit.sv
// Division: bit-serial restoring division by the radix for each of the D digits;
// then one beat per character, sign first, each beat waiting while the output stalls.
// A new item is taken only after the last character of the previous one is issued;
// the single restoring divide step is shared over all bits of all digits.
// Invalid base: item accepted and dropped; the sequencer stays idle.
// Reset (synchronous) clears the sequencer, output valid and all config
// registers, so the base reads invalid until configured.
`timescale 1ns / 1ps
`default_nettype none
module signed_radix_digit_emitter_unit (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output      logic                                   req_stall,
   input  wire logic signed [srde_pkg::VALUE_W-1:0]    req_value,
   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_stall,
   output      logic [srde_pkg::CHAR_W-1:0]            rsp_out_char,
   output      logic                                   rsp_last_char,
   input  wire logic                                   csr_valid,
   output      logic                                   csr_ready,
   input  wire logic [srde_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [srde_pkg::CSR_DATA_W-1:0]        csr_data
);
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_DIV   = 2'd1;
   localparam logic [1:0] ST_SIGN  = 2'd2;
   localparam logic [1:0] ST_DIGIT = 2'd3;

   localparam int TBL_W = srde_pkg::TABLE_ENTRIES * srde_pkg::CHAR_W;

   logic [srde_pkg::RADIX_W-1:0]    radix_ff;
   logic [srde_pkg::CSR_DATA_W-1:0] chars_low_ff;
   logic [srde_pkg::CSR_DATA_W-1:0] chars_high_ff;

   logic [1:0]                      state_ff, state_in;
   logic [srde_pkg::RADIX_W-1:0]    r_ff, r_in;
   logic                            neg_ff, neg_in;
   logic [srde_pkg::VALUE_W-1:0]    mag_ff, mag_in;
   logic [srde_pkg::DIGIT_W-1:0]    rem_ff, rem_in;
   logic [4:0]                      step_ff, step_in;
   logic [srde_pkg::COUNT_W-1:0]    nd_ff, nd_in;
   logic [srde_pkg::INDEX_W-1:0]    idx_ff, idx_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [srde_pkg::CHAR_W-1:0]     rsp_char_ff, rsp_char_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic [srde_pkg::DIGIT_W-1:0]    digits_ff [srde_pkg::MAX_DIGITS];

   logic [TBL_W-1:0]                tbl;
   logic                            base_ok;
   logic                            req_accept;
   logic [srde_pkg::VALUE_W-1:0]    raw;
   logic [srde_pkg::DIGIT_W:0]      trial;
   logic                            qbit;
   logic [srde_pkg::DIGIT_W-1:0]    rem_next;
   logic [srde_pkg::VALUE_W-1:0]    quo_next;
   logic                            digit_done;
   logic                            out_free;
   logic [srde_pkg::DIGIT_W-1:0]    rd_digit_ff;

   assign tbl        = {chars_high_ff, chars_low_ff};
   assign csr_ready  = 1'b1;
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign raw        = req_value;

   // Base check: radix in range, every used entry legal and distinct; independent compares.
   always_comb begin
      logic [srde_pkg::CHAR_W-1:0] c;
      base_ok = (radix_ff >= srde_pkg::MIN_RADIX)
             && (radix_ff <= srde_pkg::RADIX_W'(srde_pkg::MAX_RADIX))
             && (radix_ff <= srde_pkg::RADIX_W'(srde_pkg::TABLE_ENTRIES));
      for (int i = 0; i < srde_pkg::TABLE_ENTRIES; i++) begin
         c = tbl[i*srde_pkg::CHAR_W +: srde_pkg::CHAR_W];
         if (srde_pkg::RADIX_W'(i) < radix_ff) begin
            if (c == srde_pkg::CHAR_NUL || c == srde_pkg::CHAR_PLUS
                || c == srde_pkg::CHAR_MINUS)
               base_ok = 1'b0;
            for (int j = i + 1; j < srde_pkg::TABLE_ENTRIES; j++) begin
               if (srde_pkg::RADIX_W'(j) < radix_ff
                   && tbl[j*srde_pkg::CHAR_W +: srde_pkg::CHAR_W] == c)
                  base_ok = 1'b0;
            end
         end
      end
   end

   // Restoring divide step: one quotient bit per cycle, quotient shifts into mag.
   assign trial      = {rem_ff, mag_ff[srde_pkg::VALUE_W-1]};
   assign qbit       = (trial >= r_ff);
   assign rem_next   = qbit ? srde_pkg::DIGIT_W'(trial - r_ff)
                            : srde_pkg::DIGIT_W'(trial);
   assign quo_next   = {mag_ff[srde_pkg::VALUE_W-2:0], qbit};
   assign digit_done = (state_ff == ST_DIV) && (step_ff == 5'd31);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      r_in         = r_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      nd_in        = nd_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_valid_ff && !rsp_stall)
         rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && base_ok) begin
               state_in = ST_DIV;
               r_in     = radix_ff;
               neg_in   = raw[srde_pkg::VALUE_W-1];
               mag_in   = raw[srde_pkg::VALUE_W-1] ? (32'd0 - raw) : raw;
               rem_in   = '0;
               step_in  = '0;
               nd_in    = '0;
            end
         end
         ST_DIV: begin
            mag_in  = quo_next;
            rem_in  = rem_next;
            step_in = step_ff + 5'd1;
            if (digit_done) begin
               rem_in = '0;
               nd_in  = nd_ff + srde_pkg::COUNT_W'(1);
               if (quo_next == '0 || nd_ff == srde_pkg::COUNT_W'(srde_pkg::MAX_DIGITS - 1)) begin
                  idx_in   = nd_ff[srde_pkg::INDEX_W-1:0];
                  state_in = neg_ff ? ST_SIGN : ST_DIGIT;
               end
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = srde_pkg::CHAR_MINUS;
               rsp_last_in  = 1'b0;
               state_in     = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = tbl[rd_digit_ff*srde_pkg::CHAR_W +: srde_pkg::CHAR_W];
               rsp_last_in  = (idx_ff == '0);
               idx_in       = idx_ff - srde_pkg::INDEX_W'(1);
               if (idx_ff == '0)
                  state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         radix_ff      <= '0;
         chars_low_ff  <= '0;
         chars_high_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               srde_pkg::REG_RADIX:      radix_ff      <= csr_data[srde_pkg::RADIX_W-1:0];
               srde_pkg::REG_CHARS_LOW:  chars_low_ff  <= csr_data;
               srde_pkg::REG_CHARS_HIGH: chars_high_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      r_ff        <= r_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      nd_ff       <= nd_in;
      idx_ff      <= idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      if (digit_done)
         digits_ff[nd_ff[srde_pkg::INDEX_W-1:0]] <= rem_next;
      // digit for the next index; forward the digit written this cycle
      if (digit_done && idx_in == nd_ff[srde_pkg::INDEX_W-1:0])
         rd_digit_ff <= rem_next;
      else
         rd_digit_ff <= digits_ff[idx_in];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_char  = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

`ifndef ASSERT_OFF
   a_rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (srde_pkg::RADIX_W'(rem_ff) < r_ff))
      else $error("division remainder not below radix");

   a_invalid_base_drops: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !base_ok) |=> (state_ff == ST_IDLE && !req_stall))
      else $error("item with invalid base started work");

   a_digit_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (nd_ff < srde_pkg::COUNT_W'(srde_pkg::MAX_DIGITS)))
      else $error("digit buffer overrun");

   a_emit_has_digits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGIT) |-> (nd_ff != '0))
      else $error("emitting with an empty digit buffer");
`endif
endmodule
`default_nettype wire

### test/signed_radix_digit_emitter_unit_tb.sv
// Self-checking testbench: radix text conversion with random configs, gaps and stalls.
`timescale 1ns / 1ps
module signed_radix_digit_emitter_unit_tb;

   localparam logic [srde_pkg::CSR_INDEX_W-1:0] REG_SPARE = 2'd3;  // unmapped, writes are dropped
   localparam int TARGET_VALUES = 300;
   localparam int SETTLE_CYCLES = 32 * srde_pkg::MAX_DIGITS + srde_pkg::MAX_DIGITS + 64;
   localparam int IDLE_LIMIT    = 20000;

   typedef struct packed {
      logic [srde_pkg::CHAR_W-1:0] ch;
      logic                        last;
   } char_beat_type;

   class digit_text_tracker_type;
      logic [srde_pkg::RADIX_W-1:0]    radix;
      logic [srde_pkg::CSR_DATA_W-1:0] chars_low;
      logic [srde_pkg::CSR_DATA_W-1:0] chars_high;
      char_beat_type                   pending_chars[$];
      int                              errors;

      function new();
         radix      = '0;
         chars_low  = '0;
         chars_high = '0;
         errors     = 0;
      endfunction

      function void set_reg(logic [srde_pkg::CSR_INDEX_W-1:0] idx,
                            logic [srde_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            srde_pkg::REG_RADIX:      radix      = data[srde_pkg::RADIX_W-1:0];
            srde_pkg::REG_CHARS_LOW:  chars_low  = data;
            srde_pkg::REG_CHARS_HIGH: chars_high = data;
            default: ;
         endcase
      endfunction

      function logic [srde_pkg::CHAR_W-1:0] digit_char(int unsigned d);
         if (d < 8)
            return chars_low[8*d +: 8];
         return chars_high[8*(d-8) +: 8];
      endfunction

      function bit base_ok();
         int unsigned                 r;
         logic [srde_pkg::CHAR_W-1:0] c;
         r = 32'(radix);
         if (r < srde_pkg::MIN_RADIX || r > srde_pkg::MAX_RADIX
             || r > srde_pkg::TABLE_ENTRIES)
            return 0;
         for (int i = 0; i < r; i++) begin
            c = digit_char(i);
            if (c == srde_pkg::CHAR_NUL || c == srde_pkg::CHAR_PLUS
                || c == srde_pkg::CHAR_MINUS)
               return 0;
            for (int j = i + 1; j < r; j++)
               if (digit_char(j) == c)
                  return 0;
         end
         return 1;
      endfunction

      // Queue the characters one accepted value turns into.
      function void note_value(logic [srde_pkg::VALUE_W-1:0] raw);
         logic [srde_pkg::VALUE_W-1:0] mag;
         logic [srde_pkg::VALUE_W-1:0] rdx;
         logic [srde_pkg::DIGIT_W-1:0] digits[$];
         char_beat_type                beat;
         if (!base_ok())
            return;
         rdx = srde_pkg::VALUE_W'(radix);
         // unsigned negate keeps the most negative value exact
         mag = raw[srde_pkg::VALUE_W-1] ? -raw : raw;
         do begin
            digits.push_front(srde_pkg::DIGIT_W'(mag % rdx));
            mag = mag / rdx;
         end while (mag != 0);
         if (raw[srde_pkg::VALUE_W-1]) begin
            beat.ch   = srde_pkg::CHAR_MINUS;
            beat.last = 1'b0;
            pending_chars.push_back(beat);
         end
         foreach (digits[k]) begin
            beat.ch   = digit_char(digits[k]);
            beat.last = (k == digits.size() - 1);
            pending_chars.push_back(beat);
         end
      endfunction

      task report_mismatch(string msg);
         errors++;
         $display("ERROR @%0t: %s", $time, msg);
      endtask

      task check_char(logic [srde_pkg::CHAR_W-1:0] ch, logic last);
         char_beat_type want;
         if (pending_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected beat char=%h last=%b", ch, last));
            return;
         end
         want = pending_chars.pop_front();
         if (ch !== want.ch)
            report_mismatch($sformatf("out_char %h, want %h", ch, want.ch));
         if (last !== want.last)
            report_mismatch($sformatf("last_char %b, want %b", last, want.last));
      endtask

      function int pending();
         return pending_chars.size();
      endfunction
   endclass

   logic                                  clock;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_stall;
   logic signed [srde_pkg::VALUE_W-1:0]   req_value;
   logic                                  rsp_valid;
   logic                                  rsp_stall;
   logic [srde_pkg::CHAR_W-1:0]           rsp_out_char;
   logic                                  rsp_last_char;
   logic                                  csr_valid;
   logic                                  csr_ready;
   logic [srde_pkg::CSR_INDEX_W-1:0]      csr_index;
   logic [srde_pkg::CSR_DATA_W-1:0]       csr_data;

   digit_text_tracker_type tracker = new();
   bit                     no_gaps;
   int                     idle_cycles = 0;

   signed_radix_digit_emitter_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         return 0;
      if (pick < 88)
         return $urandom_range(1, 3);
      if (pick < 97)
         return $urandom_range(4, 15);
      return $urandom_range(30, 80);
   endfunction

   function automatic logic [127:0] text_table(int r);
      string        digits_txt = "0123456789ABCDEF";
      logic [127:0] t;
      t = {16{srde_pkg::CHAR_MINUS}};  // unused entries must not matter
      for (int i = 0; i < r; i++)
         t[8*i +: 8] = digits_txt[i];
      return t;
   endfunction

   function automatic logic [srde_pkg::VALUE_W-1:0] pick_value(int r);
      longint                       p;
      int                           k;
      logic [srde_pkg::VALUE_W-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $urandom;
         4, 5:       v = $urandom_range(0, r * r * r);
         6:          v = -$urandom_range(0, r * r);
         7, 8: begin
            // land on or just below a power of the radix
            p = 1;
            k = $urandom_range(1, 31);
            repeat (k)
               if (p * r <= 64'h7FFF_FFFF)
                  p = p * r;
            v = srde_pkg::VALUE_W'(p - longint'($urandom_range(0, 1)));
            if ($urandom_range(0, 1))
               v = -v;
         end
         default: begin
            case ($urandom_range(0, 4))
               0:       v = 32'h0000_0000;
               1:       v = 32'h8000_0000;
               2:       v = 32'h7FFF_FFFF;
               3:       v = 32'hFFFF_FFFF;
               default: v = 32'h0000_0001;
            endcase
         end
      endcase
      return v;
   endfunction

   task automatic send_value(input logic [srde_pkg::VALUE_W-1:0] v);
      int gap;
      gap = no_gaps ? 0 : gap_len();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_value <= $urandom;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() != 0)
         @(posedge clock);
   endtask

   // an invalid base drops items silently, so give the divider time to finish
   task automatic settle();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [srde_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [srde_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input int r, input logic [127:0] tbl);
      logic [srde_pkg::CSR_DATA_W-1:0] word;
      settle();
      word = {$urandom, $urandom};
      word[srde_pkg::RADIX_W-1:0] = srde_pkg::RADIX_W'(r);
      csr_write(srde_pkg::REG_RADIX, word);
      csr_write(srde_pkg::REG_CHARS_LOW, tbl[63:0]);
      csr_write(srde_pkg::REG_CHARS_HIGH, tbl[127:64]);
      if ($urandom_range(0, 1))
         csr_write(REG_SPARE, {$urandom, $urandom});
      no_gaps = ($urandom_range(0, 3) == 0);
   endtask

   // result side back-pressure
   initial begin
      int run_len;
      int hold_len;
      rsp_stall = 1'b0;
      run_len   = 0;
      hold_len  = 0;
      forever begin
         @(negedge clock);
         if (hold_len > 0) begin
            rsp_stall <= 1'b1;
            hold_len--;
         end else if (run_len > 0) begin
            rsp_stall <= 1'b0;
            run_len--;
         end else begin
            rsp_stall <= 1'b0;
            run_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(0, 12);
            hold_len = gap_len();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            tracker.note_value(req_value);
         if (rsp_valid === 1'b1 && !rsp_stall)
            tracker.check_char(rsp_out_char, rsp_last_char);
         if (csr_valid && csr_ready)
            tracker.set_reg(csr_index, csr_data);
         if ((req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      int                          r;
      int                          n;
      int                          i;
      int                          j;
      int                          valid_count;
      bit                          bad;
      logic [127:0]                tbl;
      logic [255:0]                taken;
      logic [srde_pkg::CHAR_W-1:0] c;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      no_gaps   = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // out of reset the radix is 0: nothing may come out
      send_value(32'h0000_0000);
      send_value(32'h8000_0000);

      configure(10, text_table(10));
      send_value(32'h0000_0000);
      send_value(32'h0000_0001);
      send_value(32'hFFFF_FFFF);
      send_value(32'h7FFF_FFFF);
      send_value(32'h8000_0000);
      send_value(32'd1234567890);
      send_value(32'hFFFF_FFF6);
      drain();
      send_value(32'd9);

      // binary: most negative value gives the longest run
      configure(2, text_table(2));
      send_value(32'h8000_0000);
      send_value(32'h7FFF_FFFF);
      send_value(32'hFFFF_FFFF);

      configure(16, text_table(16));
      csr_write(REG_SPARE, '0);
      send_value(32'hDEAD_BEEF);
      send_value(32'd15);
      send_value(32'd16);

      // broken bases
      tbl = text_table(16);
      tbl[8*5 +: 8] = tbl[8*3 +: 8];
      configure(16, tbl);
      send_value(32'd12345);
      tbl = text_table(16);
      tbl[7:0] = srde_pkg::CHAR_PLUS;
      configure(16, tbl);
      send_value(32'd77);
      tbl = text_table(8);
      tbl[8*7 +: 8] = srde_pkg::CHAR_MINUS;
      configure(8, tbl);
      send_value(32'hFFFF_0000);
      tbl = text_table(16);
      tbl[8*15 +: 8] = srde_pkg::CHAR_NUL;
      configure(16, tbl);
      send_value(32'd255);
      configure(1, text_table(16));
      send_value(32'd3);
      configure(17, text_table(16));
      send_value(32'd4);
      configure(31, text_table(16));
      send_value(32'h8000_0000);

      valid_count = 0;
      while (valid_count < TARGET_VALUES) begin
         r = $urandom_range(2, 16);
         tbl = {$urandom, $urandom, $urandom, $urandom};
         taken = '0;
         taken[srde_pkg::CHAR_NUL]   = 1'b1;
         taken[srde_pkg::CHAR_PLUS]  = 1'b1;
         taken[srde_pkg::CHAR_MINUS] = 1'b1;
         for (i = 0; i < r; i++) begin
            do c = srde_pkg::CHAR_W'($urandom_range(1, 255)); while (taken[c]);
            taken[c] = 1'b1;
            tbl[8*i +: 8] = c;
         end
         bad = ($urandom_range(0, 6) == 0);
         if (bad) begin
            case ($urandom_range(0, 2))
               0: begin
                  i = $urandom_range(0, r - 1);
                  case ($urandom_range(0, 3))
                     0: begin
                        do j = $urandom_range(0, r - 1); while (j == i);
                        tbl[8*i +: 8] = tbl[8*j +: 8];
                     end
                     1:       tbl[8*i +: 8] = srde_pkg::CHAR_PLUS;
                     2:       tbl[8*i +: 8] = srde_pkg::CHAR_MINUS;
                     default: tbl[8*i +: 8] = srde_pkg::CHAR_NUL;
                  endcase
               end
               1:       r = $urandom_range(0, 1);
               default: r = $urandom_range(17, 31);
            endcase
         end
         configure(r, tbl);
         n = bad ? $urandom_range(1, 3) : $urandom_range(5, 30);
         repeat (n) begin
            send_value(pick_value(r));
            if (tracker.base_ok())
               valid_count++;
            if ($urandom_range(0, 39) == 0)
               drain();
         end
      end

      settle();
      if (tracker.errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
